[rtl/hbd_pkg.sv]
`default_nettype none

package hbd_pkg;

    // Width of the saturating byte counter.
    localparam int COUNT_BITS = 40;
    // Width of a chunk size value taken from a size line.
    localparam int CHUNK_SIZE_BITS = 32;
    // Width of the limit and length registers.
    localparam int REG_BITS = 40;
    // Width used for limit sums and compares, wide enough for every operand.
    localparam int CMP_BITS = ((COUNT_BITS > REG_BITS) ? COUNT_BITS : REG_BITS) + 2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_BODY_MODE      = 2'd0,
        CFG_MAX_BODY_SIZE  = 2'd1,
        CFG_CONTENT_LENGTH = 2'd2
    } cfg_index_t;

    // Framing modes.
    typedef enum logic {
        MODE_LENGTH  = 1'b0,
        MODE_CHUNKED = 1'b1
    } body_mode_t;

    // Parser phase for chunked coding.
    typedef enum logic [1:0] {
        PH_LINE    = 2'd0,
        PH_LINE_CR = 2'd1,
        PH_DATA    = 2'd2,
        PH_SEP     = 2'd3
    } phase_t;

    // Completion status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LARGE   = 2'd1,
        ST_BADLINE = 2'd2
    } status_t;

    // Decoded hex digit.
    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.ok    = 1'b1;
        d.value = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            d.value = 4'(c - 8'h30);
        end else if (c inside {[8'h61:8'h66]}) begin
            d.value = 4'(c - 8'h57);
        end else if (c inside {[8'h41:8'h46]}) begin
            d.value = 4'(c - 8'h37);
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[rtl/http_body_dechunker_unit.sv]
// HTTP request body dechunker. Raw body bytes enter on the s_ channel, one
// byte per transaction, and each byte yields exactly one result transaction
// on the m_ channel telling whether it is payload, whether it was taken, and
// whether the body is complete with its status. In content length mode bytes
// pass until the declared length has been taken; in chunked mode hex size
// lines, chunk data and the two separator bytes are parsed, ending at a
// zero-size chunk. A byte is accepted every cycle while s_ready is high: the
// whole parse of one byte is counter and compare logic into the result
// register, and s_ready stays high while the result register is empty or
// being drained. After the body ends, results report done until reset.
// Configuration is written through the cfg_ channel, always ready; the user
// must write it only while the block is idle, which the block does not enforce.
`default_nettype none

module http_body_dechunker_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [hbd_pkg::REG_BITS-1:0] cfg_data,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_body_byte,
    output logic             m_body_valid,
    output logic             m_consumed,
    output logic             m_done_res,
    output logic [1:0]       m_status
);

    localparam int CB = hbd_pkg::COUNT_BITS;
    localparam int SB = hbd_pkg::CHUNK_SIZE_BITS;
    localparam int RB = hbd_pkg::REG_BITS;
    localparam int WB = hbd_pkg::CMP_BITS;

    // Configuration registers.
    hbd_pkg::body_mode_t body_mode_reg;
    logic [RB-1:0]       max_body_size_reg;
    logic [RB-1:0]       declared_len_reg;

    // Parser state.
    hbd_pkg::phase_t  phase_reg, phase_next;
    logic [SB-1:0]    chunk_left_reg, chunk_left_next;
    logic [SB-1:0]    size_accum_reg, size_accum_next;
    logic [1:0]       line_count_reg, line_count_next;
    logic [CB-1:0]    total_count_reg, total_count_next;
    logic             finished_reg, finished_next;
    hbd_pkg::status_t error_code_reg, error_code_next;

    // Result register.
    logic       m_valid_reg;
    logic [7:0] body_byte_reg, body_byte_next;
    logic       body_valid_reg, body_valid_next;
    logic       consumed_reg, consumed_next;

    logic s_fire;

    // Per-byte helper values.
    hbd_pkg::hex_digit_t hex;
    logic [CB-1:0] total_inc;
    logic          limit_on;
    logic          inc_over_limit;
    logic          chunk_over_limit;
    logic [WB-1:0] chunk_need;
    logic [SB-1:0] chunk_dec;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            body_mode_reg     <= hbd_pkg::MODE_LENGTH;
            max_body_size_reg <= '0;
            declared_len_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                hbd_pkg::CFG_BODY_MODE:      body_mode_reg <= hbd_pkg::body_mode_t'(cfg_data[0]);
                hbd_pkg::CFG_MAX_BODY_SIZE:  max_body_size_reg <= cfg_data;
                hbd_pkg::CFG_CONTENT_LENGTH: declared_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Shared counter and limit arithmetic.
    always_comb begin
        hex       = hbd_pkg::hex_decode(s_data_byte);
        total_inc = (total_count_reg != hbd_pkg::COUNT_MAX) ?
                    total_count_reg + CB'(1) : total_count_reg;
        limit_on  = (max_body_size_reg != '0);
        inc_over_limit = WB'(total_inc) > WB'(max_body_size_reg);
        chunk_need = WB'(total_inc) + WB'(size_accum_reg) + WB'(2);
        chunk_over_limit = chunk_need > WB'(max_body_size_reg);
        chunk_dec = (chunk_left_reg != '0) ? chunk_left_reg - SB'(1) : '0;
    end

    // Next state and result for the byte offered on the input channel.
    always_comb begin
        phase_next       = phase_reg;
        chunk_left_next  = chunk_left_reg;
        size_accum_next  = size_accum_reg;
        line_count_next  = line_count_reg;
        total_count_next = total_count_reg;
        finished_next    = finished_reg;
        error_code_next  = error_code_reg;
        body_valid_next  = 1'b0;
        consumed_next    = 1'b0;

        if (!finished_reg) begin
            if (body_mode_reg == hbd_pkg::MODE_LENGTH) begin
                if (limit_on && (declared_len_reg > max_body_size_reg)) begin
                    error_code_next = hbd_pkg::ST_LARGE;
                    finished_next   = 1'b1;
                end else if (WB'(total_count_reg) >= WB'(declared_len_reg)) begin
                    finished_next = 1'b1;
                end else begin
                    total_count_next = total_inc;
                    body_valid_next  = 1'b1;
                    consumed_next    = 1'b1;
                    if (WB'(total_inc) >= WB'(declared_len_reg)) begin
                        finished_next = 1'b1;
                    end
                end
            end else begin
                consumed_next    = 1'b1;
                total_count_next = total_inc;
                case (phase_reg)
                    hbd_pkg::PH_LINE: begin
                        if (line_count_reg != 2'd2) begin
                            line_count_next = line_count_reg + 2'd1;
                        end
                        if (limit_on && inc_over_limit) begin
                            error_code_next = hbd_pkg::ST_LARGE;
                            finished_next   = 1'b1;
                        end else if (s_data_byte == hbd_pkg::CHAR_CR) begin
                            phase_next = hbd_pkg::PH_LINE_CR;
                        end else if (!hex.ok || (size_accum_reg[SB-1 -: 4] != 4'd0)) begin
                            error_code_next = hbd_pkg::ST_BADLINE;
                            finished_next   = 1'b1;
                        end else begin
                            size_accum_next = {size_accum_reg[SB-5:0], hex.value};
                        end
                    end
                    hbd_pkg::PH_LINE_CR: begin
                        if (limit_on && inc_over_limit) begin
                            error_code_next = hbd_pkg::ST_LARGE;
                            finished_next   = 1'b1;
                        end else if ((s_data_byte != hbd_pkg::CHAR_LF) ||
                                     (line_count_reg < 2'd2)) begin
                            error_code_next = hbd_pkg::ST_BADLINE;
                            finished_next   = 1'b1;
                        end else if (limit_on && chunk_over_limit) begin
                            error_code_next = hbd_pkg::ST_LARGE;
                            finished_next   = 1'b1;
                        end else if (size_accum_reg == '0) begin
                            // Zero-size chunk ends the body.
                            finished_next = 1'b1;
                        end else begin
                            chunk_left_next = size_accum_reg;
                            size_accum_next = '0;
                            line_count_next = 2'd0;
                            phase_next      = hbd_pkg::PH_DATA;
                        end
                    end
                    hbd_pkg::PH_DATA: begin
                        body_valid_next = 1'b1;
                        chunk_left_next = chunk_dec;
                        if (chunk_dec == '0) begin
                            chunk_left_next = SB'(2);
                            phase_next      = hbd_pkg::PH_SEP;
                        end
                    end
                    default: begin
                        // Separator bytes are skipped without a check.
                        chunk_left_next = chunk_dec;
                        if (chunk_dec == '0) begin
                            size_accum_next = '0;
                            line_count_next = 2'd0;
                            phase_next      = hbd_pkg::PH_LINE;
                        end
                    end
                endcase
            end
        end

        body_byte_next = body_valid_next ? s_data_byte : 8'd0;
    end

    // Parser state registers, updated once per accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= hbd_pkg::PH_LINE;
            chunk_left_reg  <= '0;
            size_accum_reg  <= '0;
            line_count_reg  <= 2'd0;
            total_count_reg <= '0;
            finished_reg    <= 1'b0;
            error_code_reg  <= hbd_pkg::ST_OK;
        end else if (s_fire) begin
            phase_reg       <= phase_next;
            chunk_left_reg  <= chunk_left_next;
            size_accum_reg  <= size_accum_next;
            line_count_reg  <= line_count_next;
            total_count_reg <= total_count_next;
            finished_reg    <= finished_next;
            error_code_reg  <= error_code_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            body_byte_reg  <= body_byte_next;
            body_valid_reg <= body_valid_next;
            consumed_reg   <= consumed_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_body_byte  = body_byte_reg;
    assign m_body_valid = body_valid_reg;
    assign m_consumed   = consumed_reg;
    assign m_done_res   = finished_reg;
    assign m_status     = error_code_reg;

endmodule

`default_nettype wire

[rtl/hbd_checker.sv]
`default_nettype none

module hbd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [7:0]  m_body_byte,
    input wire logic        m_body_valid,
    input wire logic        m_consumed,
    input wire logic        m_done_res,
    input wire logic [1:0]  m_status
);

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_body_byte) &&
        $stable(m_body_valid) && $stable(m_consumed))
        else $error("result changed while stalled");

    // With no result pending the input side must be open.
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // A byte that is not payload carries zero.
    a_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_body_valid |-> m_body_byte == 8'd0)
        else $error("non-payload result carries data");

    // Payload is always a taken byte.
    a_payload_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_body_valid |-> m_consumed)
        else $error("payload byte not marked consumed");

    // An error status always ends the body.
    a_error_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != hbd_pkg::ST_OK) |-> m_done_res)
        else $error("error status without done");

endmodule

bind http_body_dechunker_unit hbd_checker u_hbd_checker (.*);

`default_nettype wire
